/* rtl/pafbf_pkg.sv */
// ----------------------------------------------------------------------------
// pafbf_pkg
// Shared types and codes for the partition allocator.
// ----------------------------------------------------------------------------
package pafbf_pkg;

	localparam int JOB_W    = 8;
	localparam int SIZE_W   = 11;
	localparam int ADDR_W   = 10;
	localparam int STATUS_W = 2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic POL_FIRST = 1'b0;

	typedef struct packed {
		logic load;
		logic step;
		logic take;
		logic split;
		logic grant_only;
		logic release_ent;
		logic merge_next;
		logic to_prev;
		logic merge_prev;
	} cmd_t;

	typedef struct packed {
		logic policy;
		logic fit;
		logic exact;
		logic better;
		logic found;
		logic last;
		logic match;
		logic entry_busy;
		logic len_gt;
		logic full;
		logic nb_ok;
		logic pick_nz;
	} sts_t;

endpackage

/* rtl/partition_allocator_first_best_fit.sv */
// ----------------------------------------------------------------------------
// partition_allocator_first_best_fit
// Variable-partition allocator, first fit or best fit, with split and merge.
//
// channel   signals                                   transaction
// request   start, busy, func, job_id, request_size   start && !busy
// result    done, status, grant_address               done, one cycle
// config    cfg_we, cfg_wdata (fit_policy)            cfg_we
//
// An allocation scans up to MAX_PARTS entries, one entry per cycle, then
// decides on the chosen entry; it ends after the scan when nothing fits,
// and a zero size ends with no scan. A free scans until it finds the job,
// then merges a released busy partition with its free neighbours.
// Reset restores one free partition holding the whole pool, fit_policy 0.
// The result cannot be stalled; a new start is taken in the done cycle.
// ----------------------------------------------------------------------------
module partition_allocator_first_best_fit #(
	parameter int POOL_UNITS = 1024,
	parameter int MAX_PARTS  = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               func,
	input  logic [pafbf_pkg::JOB_W-1:0]        job_id,
	input  logic [pafbf_pkg::SIZE_W-1:0]       request_size,
	output logic                               done,
	output logic [pafbf_pkg::STATUS_W-1:0]     status,
	output logic [pafbf_pkg::ADDR_W-1:0]       grant_address,
	input  logic                               cfg_we,
	input  logic                               cfg_wdata
);

	pafbf_pkg::cmd_t cmd;
	pafbf_pkg::sts_t sts;

	pafbf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.func         (func),
		.request_size (request_size),
		.sts          (sts),
		.cmd          (cmd),
		.busy         (busy),
		.done         (done),
		.status       (status)
	);

	pafbf_dp #(
		.POOL_UNITS (POOL_UNITS),
		.MAX_PARTS  (MAX_PARTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.job_id        (job_id),
		.request_size  (request_size),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.sts           (sts),
		.grant_address (grant_address)
	);

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");
	a_start_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done)) else $error("transaction dropped");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != pafbf_pkg::ST_OK) |-> (grant_address == '0))
		else $error("address on failed transaction");
	a_free_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == pafbf_pkg::FUNC_FREE) |=> !done)
		else $error("free finished too early");
`endif

endmodule

/* rtl/pafbf_ctrl.sv */
// ----------------------------------------------------------------------------
// pafbf_ctrl
// Sequencer: scans the table, then splits, grants or merges.
// ----------------------------------------------------------------------------
module pafbf_ctrl (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               func,
	input  logic [pafbf_pkg::SIZE_W-1:0]       request_size,
	input  pafbf_pkg::sts_t                    sts,
	output pafbf_pkg::cmd_t                    cmd,
	output logic                               busy,
	output logic                               done,
	output logic [pafbf_pkg::STATUS_W-1:0]     status
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ASCAN,
		S_DECIDE,
		S_FSCAN,
		S_FNEXT,
		S_FPREV
	} state_t;

	state_t                            state_q;
	state_t                            state_d;
	logic                              done_d;
	logic [pafbf_pkg::STATUS_W-1:0]    status_d;
	logic                              done_q;
	logic [pafbf_pkg::STATUS_W-1:0]    status_q;
	logic                              take_now;

	assign take_now = sts.fit && (sts.policy == pafbf_pkg::POL_FIRST || sts.exact ||
		!sts.found || sts.better);

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		done_d   = 1'b0;
		status_d = pafbf_pkg::ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (func == pafbf_pkg::FUNC_FREE) begin
						state_d = S_FSCAN;
					end else if (request_size == '0) begin
						done_d   = 1'b1;
						status_d = pafbf_pkg::ST_NOFIT;
					end else begin
						state_d = S_ASCAN;
					end
				end
			end
			S_ASCAN: begin
				cmd.take = take_now;
				if (sts.fit && (sts.policy == pafbf_pkg::POL_FIRST || sts.exact)) begin
					state_d = S_DECIDE;
				end else if (sts.last) begin
					if (sts.found || take_now) begin
						state_d = S_DECIDE;
					end else begin
						state_d  = S_IDLE;
						done_d   = 1'b1;
						status_d = pafbf_pkg::ST_NOFIT;
					end
				end else begin
					cmd.step = 1'b1;
				end
			end
			S_DECIDE: begin
				state_d = S_IDLE;
				done_d  = 1'b1;
				if (sts.len_gt) begin
					if (sts.full) begin
						status_d = pafbf_pkg::ST_FULL;
					end else begin
						cmd.split = 1'b1;
					end
				end else begin
					cmd.grant_only = 1'b1;
				end
			end
			S_FSCAN: begin
				if (sts.match) begin
					if (sts.entry_busy) begin
						cmd.release_ent = 1'b1;
						state_d         = S_FNEXT;
					end else begin
						state_d = S_IDLE;
						done_d  = 1'b1;
					end
				end else if (sts.last) begin
					state_d = S_IDLE;
					done_d  = 1'b1;
				end else begin
					cmd.step = 1'b1;
				end
			end
			S_FNEXT: begin
				cmd.merge_next = sts.nb_ok;
				cmd.to_prev    = 1'b1;
				state_d        = S_FPREV;
			end
			S_FPREV: begin
				cmd.merge_prev = sts.pick_nz && sts.nb_ok;
				state_d        = S_IDLE;
				done_d         = 1'b1;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			status_q <= pafbf_pkg::ST_OK;
		end else begin
			state_q  <= state_d;
			done_q   <= done_d;
			status_q <= status_d;
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign status = status_q;

endmodule

/* rtl/pafbf_dp.sv */
// ----------------------------------------------------------------------------
// pafbf_dp
// Partition table, scan pointer, chosen entry and grant register.
// ----------------------------------------------------------------------------
module pafbf_dp #(
	parameter int POOL_UNITS = 1024,
	parameter int MAX_PARTS  = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pafbf_pkg::cmd_t                    cmd,
	input  logic [pafbf_pkg::JOB_W-1:0]        job_id,
	input  logic [pafbf_pkg::SIZE_W-1:0]       request_size,
	input  logic                               cfg_we,
	input  logic                               cfg_wdata,
	output pafbf_pkg::sts_t                    sts,
	output logic [pafbf_pkg::ADDR_W-1:0]       grant_address
);

	localparam int AW   = (POOL_UNITS > 1) ? $clog2(POOL_UNITS) : 1;
	localparam int LW   = $clog2(POOL_UNITS + 1);
	localparam int IW   = $clog2(MAX_PARTS);
	localparam int CNTW = $clog2(MAX_PARTS + 1);
	localparam int CW   = (LW > pafbf_pkg::SIZE_W) ? LW : pafbf_pkg::SIZE_W;

	logic [AW-1:0]               start_q [MAX_PARTS];
	logic [LW-1:0]               len_q   [MAX_PARTS];
	logic                        busy_q  [MAX_PARTS];
	logic [pafbf_pkg::JOB_W-1:0] owner_q [MAX_PARTS];

	logic [CNTW-1:0]             count_q;
	logic [CNTW-1:0]             idx_q;
	logic [CNTW-1:0]             pick_q;
	logic [LW-1:0]               pick_len_q;
	logic [AW-1:0]               pick_start_q;
	logic                        found_q;
	logic                        policy_q;
	logic [pafbf_pkg::JOB_W-1:0] job_q;
	logic [pafbf_pkg::SIZE_W-1:0] size_q;
	logic [pafbf_pkg::ADDR_W-1:0] grant_q;

	logic [IW-1:0]               ridx;
	logic                        in_rng;
	logic [AW-1:0]               rd_start;
	logic [LW-1:0]               rd_len;
	logic                        rd_busy;
	logic [pafbf_pkg::JOB_W-1:0] rd_owner;
	logic [CW-1:0]               sz_c;
	logic [CW-1:0]               ln_c;
	logic [CW-1:0]               pl_c;
	logic [CNTW-1:0]             pick_p1;
	logic [LW-1:0]               size_l;

	assign ridx     = idx_q[IW-1:0];
	assign in_rng   = (idx_q < count_q);
	assign rd_start = start_q[ridx];
	assign rd_len   = len_q[ridx];
	assign rd_busy  = busy_q[ridx];
	assign rd_owner = owner_q[ridx];
	assign sz_c     = CW'(size_q);
	assign ln_c     = CW'(rd_len);
	assign pl_c     = CW'(pick_len_q);
	assign pick_p1  = pick_q + CNTW'(1);
	assign size_l   = LW'(size_q);

	assign sts.policy     = policy_q;
	assign sts.fit        = in_rng && !rd_busy && (ln_c >= sz_c);
	assign sts.exact      = (ln_c == sz_c);
	assign sts.better     = (ln_c < pl_c);
	assign sts.found      = found_q;
	assign sts.last       = (idx_q == count_q - CNTW'(1));
	assign sts.match      = in_rng && (rd_owner == job_q);
	assign sts.entry_busy = rd_busy;
	assign sts.len_gt     = (pl_c > sz_c);
	assign sts.full       = (count_q >= CNTW'(MAX_PARTS));
	assign sts.nb_ok      = in_rng && !rd_busy;
	assign sts.pick_nz    = (pick_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= pafbf_pkg::POL_FIRST;
		end else if (cfg_we) begin
			policy_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNTW'(1);
			idx_q   <= '0;
			pick_q  <= '0;
			found_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else if (cmd.step) begin
				idx_q <= idx_q + CNTW'(1);
			end else if (cmd.release_ent) begin
				pick_q <= idx_q;
				idx_q  <= idx_q + CNTW'(1);
			end else if (cmd.to_prev) begin
				idx_q <= pick_q - CNTW'(1);
			end
			if (cmd.take) begin
				pick_q  <= idx_q;
				found_q <= 1'b1;
			end
			if (cmd.split) begin
				count_q <= count_q + CNTW'(1);
			end else if (cmd.merge_next || cmd.merge_prev) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			job_q   <= job_id;
			size_q  <= request_size;
			grant_q <= '0;
		end
		if (cmd.take) begin
			pick_len_q   <= rd_len;
			pick_start_q <= rd_start;
		end
		if (cmd.release_ent) begin
			pick_len_q <= rd_len;
		end
		if (cmd.merge_next) begin
			pick_len_q <= pick_len_q + rd_len;
		end
		if (cmd.split || cmd.grant_only) begin
			grant_q <= pafbf_pkg::ADDR_W'(pick_start_q);
		end
	end

	for (genvar g = 0; g < MAX_PARTS; g++) begin : g_ent
		localparam int UP = (g > 0) ? g - 1 : 0;
		localparam int DN = (g < MAX_PARTS - 1) ? g + 1 : g;
		localparam logic [CNTW-1:0] G = CNTW'(g);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				start_q[g] <= '0;
				len_q[g]   <= (g == 0) ? LW'(POOL_UNITS) : '0;
				busy_q[g]  <= 1'b0;
				owner_q[g] <= '0;
			end else if (cmd.split) begin
				if (G == pick_q) begin
					len_q[g]   <= size_l;
					busy_q[g]  <= 1'b1;
					owner_q[g] <= job_q;
				end else if (G == pick_p1) begin
					start_q[g] <= pick_start_q + AW'(size_q);
					len_q[g]   <= pick_len_q - size_l;
					busy_q[g]  <= 1'b0;
					owner_q[g] <= '0;
				end else if (G > pick_p1 && G <= count_q) begin
					start_q[g] <= start_q[UP];
					len_q[g]   <= len_q[UP];
					busy_q[g]  <= busy_q[UP];
					owner_q[g] <= owner_q[UP];
				end
			end else if (cmd.grant_only) begin
				if (G == pick_q) begin
					busy_q[g]  <= 1'b1;
					owner_q[g] <= job_q;
				end
			end else if (cmd.release_ent) begin
				if (G == idx_q) begin
					busy_q[g]  <= 1'b0;
					owner_q[g] <= '0;
				end
			end else if (cmd.merge_next) begin
				if (G == pick_q) begin
					len_q[g] <= pick_len_q + rd_len;
				end else if (G >= idx_q) begin
					start_q[g] <= start_q[DN];
					len_q[g]   <= len_q[DN];
					busy_q[g]  <= busy_q[DN];
					owner_q[g] <= owner_q[DN];
				end
			end else if (cmd.merge_prev) begin
				if (G == idx_q) begin
					len_q[g] <= rd_len + pick_len_q;
				end else if (G >= pick_q) begin
					start_q[g] <= start_q[DN];
					len_q[g]   <= len_q[DN];
					busy_q[g]  <= busy_q[DN];
					owner_q[g] <= owner_q[DN];
				end
			end
		end
	end

	assign grant_address = grant_q;

endmodule
